/* src/mbsp_pkg.sv */
// Package for the MIDI byte stream parser: status codes, state and result types.
// No dependencies; imported by mbsp_decode and the top level.
package mbsp_pkg;

    localparam logic [7:0] ST_NONE      = 8'h00;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_MTC_QF    = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_COMMON_HI = 8'hF6;
    localparam logic [7:0] ST_EOX       = 8'hF7;
    localparam logic [7:0] ST_RT_LO     = 8'hF8;

    localparam logic [3:0] NIB_PROG_CHANGE = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS  = 4'hD;

    localparam int unsigned DATA_W = 7;

    // Parser state carried from one word to the next.
    typedef struct packed {
        logic [7:0]        cur_status;
        logic [1:0]        need;
        logic [DATA_W-1:0] held_data;
        logic              holding;
        logic              excl_active;
    } parse_state_t;

    // One completed message.
    typedef struct packed {
        logic              valid;
        logic [7:0]        status;
        logic [DATA_W-1:0] data1;
        logic [DATA_W-1:0] data2;
    } msg_t;

    function automatic logic is_common(input logic [7:0] st);
        return (st >= ST_MTC_QF) && (st <= ST_COMMON_HI);
    endfunction

endpackage

/* src/mbsp_decode.sv */
// Per-word decision logic of the MIDI parser: next state and completed message.
// Depends on mbsp_pkg.
module mbsp_decode (
    input  logic [7:0]           byte_in,
    input  mbsp_pkg::parse_state_t cur,
    output mbsp_pkg::parse_state_t nxt,
    output mbsp_pkg::msg_t       msg
);
    import mbsp_pkg::*;

    always_comb
    begin
        nxt        = cur;
        msg.valid  = 1'b0;
        msg.status = cur.cur_status;
        msg.data1  = '0;
        msg.data2  = '0;
        if (byte_in >= ST_RT_LO)
        begin
            // real-time: pass straight out, state untouched
            msg.valid  = 1'b1;
            msg.status = byte_in;
        end
        else if (cur.excl_active && !byte_in[7])
        begin
            // sysex payload swallowed
        end
        else
        begin
            nxt.excl_active = 1'b0;
            if (byte_in[7])
            begin
                nxt.holding = 1'b0;
                if (byte_in == ST_SYSEX)
                begin
                    nxt.excl_active = 1'b1;
                    nxt.cur_status  = ST_NONE;
                end
                else if (byte_in == ST_EOX)
                begin
                    nxt.cur_status = ST_NONE;
                end
                else if (is_common(byte_in))
                begin
                    nxt.cur_status = byte_in;
                    if (byte_in == ST_SONG_POS)
                        nxt.need = 2'd2;
                    else if (byte_in == ST_MTC_QF || byte_in == ST_SONG_SEL)
                        nxt.need = 2'd1;
                    else
                        nxt.need = 2'd0;
                end
                else
                begin
                    nxt.cur_status = byte_in;
                    if (byte_in[7:4] == NIB_PROG_CHANGE || byte_in[7:4] == NIB_CHAN_PRESS)
                        nxt.need = 2'd1;
                    else
                        nxt.need = 2'd2;
                end
            end
            else if (cur.cur_status == ST_NONE)
            begin
                // data with no status: dropped
            end
            else if (is_common(cur.cur_status))
            begin
                nxt.holding = (cur.need <= 2'd1) ? 1'b0 : !cur.holding;
            end
            else if (cur.need == 2'd1)
            begin
                msg.valid = 1'b1;
                msg.data1 = byte_in[DATA_W-1:0];
            end
            else if (!cur.holding)
            begin
                nxt.held_data = byte_in[DATA_W-1:0];
                nxt.holding   = 1'b1;
            end
            else
            begin
                nxt.holding = 1'b0;
                msg.valid   = 1'b1;
                msg.data1   = cur.held_data;
                msg.data2   = byte_in[DATA_W-1:0];
            end
        end
    end

endmodule

/* src/midi_byte_stream_parser_core.sv */
// MIDI byte stream parser, top level: state register, decode, output + skid stage.
// Depends on mbsp_pkg and mbsp_decode.
// Latency: a completing word shows its message in the cycle after acceptance if the
// output register is free or drains that cycle; otherwise it waits in the skid stage behind a stalled output.
// Throughput: one word per cycle; only the skid stage being full stalls the input.
// Reset (rst_n low, async): no running status, no held byte, no sysex, output empty.
module midi_byte_stream_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] status_byte,
    output logic [6:0] first_data,
    output logic [6:0] second_data
);
    import mbsp_pkg::*;

    parse_state_t state_reg, state_next;
    msg_t         dec_msg;
    msg_t         out_reg;
    msg_t         skid_reg;

    logic in_take;
    logic out_take;
    logic new_msg;

    // Stall only when the skid word is occupied; registered, so no path from out_stall.
    assign in_stall = skid_reg.valid;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_reg.valid && !out_stall;
    assign new_msg  = in_take && dec_msg.valid;

    mbsp_decode u_decode (
        .byte_in (midi_byte),
        .cur     (state_reg),
        .nxt     (state_next),
        .msg     (dec_msg)
    );

    // Parser state advances on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_take)
            state_reg <= state_next;
    end

    // Output register with a one-word skid behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg.valid  <= 1'b0;
            skid_reg.valid <= 1'b0;
        end
        else if (skid_reg.valid)
        begin
            // input is stalled; drain skid into output when it frees up
            if (out_take)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
        end
        else if (new_msg)
        begin
            if (!out_reg.valid || out_take)
                out_reg <= dec_msg;
            else
                skid_reg <= dec_msg;
        end
        else if (out_take)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign out_valid   = out_reg.valid;
    assign status_byte = out_reg.status;
    assign first_data  = out_reg.data1;
    assign second_data = out_reg.data2;

endmodule

/* src/mbsp_checker.sv */
// Port-level assertions for the MIDI parser, bound to the top level.
// Depends on midi_byte_stream_parser_core.
module mbsp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] midi_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] status_byte,
    input logic [6:0] first_data,
    input logic [6:0] second_data
);

    // real-time word into an empty output comes straight out next cycle
    a_rt_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && midi_byte >= 8'hF8 && !out_valid)
        |=> (out_valid && status_byte == $past(midi_byte)
             && first_data == 7'd0 && second_data == 7'd0))
        else $error("real-time word not passed through");

    a_rt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_byte >= 8'hF8) |-> (first_data == 7'd0 && second_data == 7'd0))
        else $error("real-time message carries data");

    a_one_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_byte[7:4] == 4'hC || status_byte[7:4] == 4'hD))
        |-> (second_data == 7'd0))
        else $error("one-data message carries second data");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status_byte)
                                      && $stable(first_data) && $stable(second_data)))
        else $error("stalled output word changed");

endmodule

bind midi_byte_stream_parser_core mbsp_checker u_mbsp_checker (.*);
